/* hdl/base64_stream_encoder_macros.svh */
// assertion helpers shared by the encoder modules
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// checked on every clock edge outside reset
`define B64E_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* hdl/b64e_pkg.sv */
package b64e_pkg;

    localparam logic [15:0] CHAR_LIMIT_RESET    = 16'hffff;
    localparam int          QUEUE_DEPTH_DEFAULT = 2;
    localparam logic [6:0]  PAD_CHAR            = 7'h3d;

    // register index as seen on paddr[2]
    localparam logic        CFG_IDX_CHAR_LIMIT  = 1'b0;

    // one encoded group, waiting to be serialised
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [2:0]      nkeep;
        logic            eom;
    } entry_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] s);
        logic [6:0] c;
        if (s < 6'd26) begin
            c = 7'h41 + {1'b0, s};
        end else if (s < 6'd52) begin
            c = 7'h61 + {1'b0, s} - 7'd26;
        end else if (s < 6'd62) begin
            c = 7'h30 + {1'b0, s} - 7'd52;
        end else if (s == 6'd62) begin
            c = 7'h2b;
        end else begin
            c = 7'h2f;
        end
        return c;
    endfunction

endpackage

/* hdl/b64e_front.sv */
module b64e_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          char_limit,
    input  logic                 in_fire,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    input  logic                 end_of_message,
    output logic                 push,
    output b64e_pkg::entry_t     push_entry
);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] count_reg, count_next;

    logic        grp_full;
    logic [1:0]  phase_after;
    logic [15:0] held_after;
    logic        emit;
    logic [7:0]  b0, b1, b2;
    logic [2:0]  nsext;
    logic [3:0][5:0] sext;
    logic [15:0] remaining;
    logic [2:0]  nkeep;

    always_comb begin
        grp_full    = has_byte && (phase_reg == 2'd2);
        phase_after = phase_reg;
        held_after  = held_reg;
        if (has_byte && phase_reg == 2'd0) begin
            phase_after = 2'd1;
            held_after  = {data_byte, 8'h00};
        end else if (has_byte && phase_reg == 2'd1) begin
            phase_after = 2'd2;
            held_after  = {held_reg[15:8], data_byte};
        end

        emit  = 1'b0;
        b0    = held_after[15:8];
        b1    = 8'h00;
        b2    = 8'h00;
        nsext = 3'd0;
        if (grp_full) begin
            emit  = 1'b1;
            b0    = held_reg[15:8];
            b1    = held_reg[7:0];
            b2    = data_byte;
            nsext = 3'd4;
        end else if (end_of_message && phase_after == 2'd1) begin
            emit  = 1'b1;
            nsext = 3'd2;
        end else if (end_of_message && phase_after == 2'd2) begin
            emit  = 1'b1;
            b1    = held_after[7:0];
            nsext = 3'd3;
        end

        sext[0] = b0[7:2];
        sext[1] = {b0[1:0], b1[7:4]};
        sext[2] = {b1[3:0], b2[7:6]};
        sext[3] = b2[5:0];
        for (int k = 0; k < 4; k++) begin
            push_entry.chars[k] = (3'(k) < nsext) ? b64e_pkg::sextet_char(sext[k])
                                                  : b64e_pkg::PAD_CHAR;
        end

        // characters beyond the limit are dropped, always from the tail
        remaining = (count_reg < char_limit) ? (char_limit - count_reg) : 16'd0;
        if (!emit) begin
            nkeep = 3'd0;
        end else if (remaining >= 16'd4) begin
            nkeep = 3'd4;
        end else begin
            nkeep = remaining[2:0];
        end
        push_entry.nkeep = nkeep;
        push_entry.eom   = end_of_message;
        push             = in_fire && (nkeep != 3'd0);

        phase_next = phase_reg;
        held_next  = held_reg;
        count_next = count_reg;
        if (in_fire) begin
            if (end_of_message || grp_full) begin
                phase_next = 2'd0;
                held_next  = 16'h0000;
            end else begin
                phase_next = phase_after;
                held_next  = held_after;
            end
            count_next = end_of_message ? 16'd0 : count_reg + {13'd0, nkeep};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            held_reg  <= 16'h0000;
            count_reg <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

`include "base64_stream_encoder_macros.svh"

    `B64E_ASSERT(a_count_clear_at_eom, in_fire && end_of_message |=> count_reg == 16'd0, "character count not cleared at message end")

endmodule

/* hdl/b64e_queue.sv */
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  b64e_pkg::entry_t push_entry,
    input  logic             pop,
    output b64e_pkg::entry_t head,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64e_pkg::entry_t slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CW'(DEPTH));

`include "base64_stream_encoder_macros.svh"

    `B64E_ASSERT(a_no_push_when_full, !(push && full), "push into a full group queue")
    `B64E_ASSERT(a_no_pop_when_empty, !(pop && empty), "pop from an empty group queue")
    `B64E_ASSERT_ALWAYS(a_fill_in_range, !aresetn || fill_reg <= CW'(DEPTH), "group queue fill count out of range")

endmodule

/* hdl/b64e_back.sv */
module b64e_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  b64e_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       load;
    logic       is_last;

    always_comb begin
        load       = !empty && (!valid_reg || m_tready);
        is_last    = ({1'b0, idx_reg} == head.nkeep - 3'd1);
        pop        = load && is_last;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = head.chars[idx_reg];
            last_next  = is_last;
            done_next  = is_last && head.eom;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

`include "base64_stream_encoder_macros.svh"

    `B64E_ASSERT(a_idx_within_group, !empty |-> {1'b0, idx_reg} < head.nkeep, "character index past the kept characters of the group")

endmodule

/* hdl/base64_stream_encoder.sv */
// Streaming base64 encoder (standard alphabet, '=' padding). Each input
// transaction carries at most one message byte (tuser = 1) and tlast marks the
// end of a message; a transaction with tuser = 0 and tlast = 1 ends a message
// without adding a byte. Every third byte, and any partial group at message end,
// turns into one group of four characters held in a small queue; the output side
// sends one character per cycle while m_tready is high, with tlast on the last
// character produced by an input transaction and tuser on the last one from the
// transaction that ends the message, if it yields any. Transactions are taken
// one per cycle while the group queue has room, so a burst of up to three bytes
// per free queue slot passes with no stall; sustained, the output register sets
// the rate. char_limit (APB, byte address 0) caps the characters sent per
// message, further characters are dropped silently, and it should be written
// only while no transaction is in flight. No clearing pass is needed after reset.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    input  logic        s_tuser,   // [0] has_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // [0] message_done

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]      char_limit_reg, char_limit_next;
    logic             in_fire;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    b64e_pkg::entry_t push_entry;
    b64e_pkg::entry_t head;

    assign pready   = 1'b1;
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        char_limit_next = char_limit_reg;
        if (psel && penable && pwrite && pready
            && paddr[2] == b64e_pkg::CFG_IDX_CHAR_LIMIT) begin
            char_limit_next = pwdata[15:0];
        end
        prdata = 32'd0;
        if (paddr[2] == b64e_pkg::CFG_IDX_CHAR_LIMIT) begin
            prdata = {16'd0, char_limit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_limit_reg <= b64e_pkg::CHAR_LIMIT_RESET;
        end else begin
            char_limit_reg <= char_limit_next;
        end
    end

    b64e_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .char_limit     (char_limit_reg),
        .in_fire        (in_fire),
        .data_byte      (s_tdata),
        .has_byte       (s_tuser),
        .end_of_message (s_tlast),
        .push           (push),
        .push_entry     (push_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    b64e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
